>>> hw/rtl/ntfs_run_list_decoder_unit_defines.svh
// Assertion helpers shared by the run list decoder modules.
`ifndef NTFS_RUN_LIST_DECODER_UNIT_DEFINES_SVH
`define NTFS_RUN_LIST_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define RLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define RLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rld_pkg.sv
package rld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [1:0] KIND_RUN       = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    // One queued event; a run with end_too set is followed by a list end word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] lcn;
        logic [63:0] len;
        logic [15:0] count;
        logic        end_too;
    } t_entry;

endpackage

>>> hw/rtl/ntfs_run_list_decoder_unit.sv
// Run list decoder: takes an NTFS mapping-pairs run list one byte per word.
// Input channel: i_valid / o_stall with i_data_byte, i_first_byte (starts a
// new list, clears the running cluster and run count) and i_last_byte (end
// of the buffer). A byte is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_kind (run, list end, overflow,
// malformed), o_start_lcn, o_run_length, o_run_count and o_last, which marks
// the final word caused by a byte.
// Throughput: one byte per cycle while o_stall is low. A byte gives zero,
// one or two words; a run closed by the last byte of the buffer gives a run
// word then a list end word. A word for a byte is written into the queue when
// the byte is taken and reaches the ports from the output register. The parser
// feeds a four-entry queue; the output stage holds its word while i_stall is
// high and o_stall rises once the queue is full.
// Reset (i_rst_n low at a clock edge) empties the queue and output stage and
// returns the parser to expecting a header with cluster and count at zero.
module ntfs_run_list_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [63:0] o_start_lcn,
    output logic [63:0]        o_run_length,
    output logic [15:0]        o_run_count,
    output logic               o_last
);

    logic            full;
    logic            push;
    logic            pop;
    logic            q_valid;
    rld_pkg::t_entry push_entry;
    rld_pkg::t_entry q_entry;

    rld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    rld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    rld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_start_lcn   (o_start_lcn),
        .o_run_length  (o_run_length),
        .o_run_count   (o_run_count),
        .o_last        (o_last)
    );

endmodule

>>> hw/rtl/rld_front.sv
`include "ntfs_run_list_decoder_unit_defines.svh"

module rld_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_byte,
    input  logic            i_last_byte,
    input  logic            i_full,
    output logic            o_push,
    output rld_pkg::t_entry o_entry
);

    logic [1:0]  r_phase,       n_phase;
    logic [3:0]  r_length_left, n_length_left;
    logic [3:0]  r_offset_left, n_offset_left;
    logic [2:0]  r_byte_pos,    n_byte_pos;
    logic [63:0] r_length_acc,  n_length_acc;
    logic [63:0] r_delta_acc,   n_delta_acc;
    logic [63:0] r_cluster,     n_cluster;
    logic [15:0] r_runs,        n_runs;

    logic        accept;
    logic        push_c;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && push_c;

    always_comb begin
        logic [1:0]  ph;
        logic [63:0] clu;
        logic [15:0] runs;
        logic [3:0]  ln;
        logic [3:0]  on;
        logic [3:0]  len_nx;
        logic [3:0]  off_nx;
        logic [63:0] lacc_nx;
        logic [63:0] dacc_nx;
        logic        body;

        ph   = i_first_byte ? rld_pkg::PH_HEADER : r_phase;
        clu  = i_first_byte ? 64'd0 : r_cluster;
        runs = i_first_byte ? 16'd0 : r_runs;
        ln   = i_data_byte[3:0];
        on   = i_data_byte[7:4];

        lacc_nx = r_length_acc;
        dacc_nx = r_delta_acc;
        for (int k = 0; k < 8; k++) begin
            if (3'(k) == r_byte_pos) begin
                lacc_nx[8*k +: 8] = i_data_byte;
                dacc_nx[8*k +: 8] = i_data_byte;
            end else if (3'(k) > r_byte_pos) begin
                dacc_nx[8*k +: 8] = {8{i_data_byte[7]}};
            end
        end

        len_nx        = r_length_left;
        off_nx        = r_offset_left;
        body          = 1'b0;
        n_phase       = ph;
        n_length_left = r_length_left;
        n_offset_left = r_offset_left;
        n_byte_pos    = r_byte_pos;
        n_length_acc  = r_length_acc;
        n_delta_acc   = r_delta_acc;
        n_cluster     = clu;
        n_runs        = runs;
        push_c        = 1'b0;
        o_entry       = '{kind: rld_pkg::KIND_END, lcn: 64'd0, len: 64'd0,
                          count: runs, end_too: 1'b0};

        unique case (ph)
            rld_pkg::PH_HEADER: begin
                if (i_data_byte == 8'd0) begin
                    n_phase      = rld_pkg::PH_DONE;
                    push_c       = 1'b1;
                    o_entry.kind = rld_pkg::KIND_END;
                end else if (i_last_byte) begin
                    n_phase      = rld_pkg::PH_DONE;
                    push_c       = 1'b1;
                    o_entry.kind = rld_pkg::KIND_OVERFLOW;
                end else if (32'(ln) > rld_pkg::MAX_FIELD_BYTES
                             || 32'(on) > rld_pkg::MAX_FIELD_BYTES) begin
                    n_phase      = rld_pkg::PH_DONE;
                    push_c       = 1'b1;
                    o_entry.kind = rld_pkg::KIND_MALFORMED;
                end else begin
                    n_length_left = ln;
                    n_offset_left = on;
                    n_byte_pos    = 3'd0;
                    n_length_acc  = 64'd0;
                    n_delta_acc   = 64'd0;
                    n_phase       = (ln != 4'd0) ? rld_pkg::PH_LENGTH
                                                 : rld_pkg::PH_OFFSET;
                end
            end
            rld_pkg::PH_LENGTH: begin
                body          = 1'b1;
                n_length_acc  = lacc_nx;
                n_byte_pos    = r_byte_pos + 3'd1;
                len_nx        = (r_length_left != 4'd0) ? r_length_left - 4'd1 : 4'd0;
                n_length_left = len_nx;
                if (len_nx == 4'd0) begin
                    n_byte_pos = 3'd0;
                    n_phase    = rld_pkg::PH_OFFSET;
                end
            end
            rld_pkg::PH_OFFSET: begin
                body          = 1'b1;
                n_delta_acc   = dacc_nx;
                n_byte_pos    = r_byte_pos + 3'd1;
                off_nx        = (r_offset_left != 4'd0) ? r_offset_left - 4'd1 : 4'd0;
                n_offset_left = off_nx;
            end
            rld_pkg::PH_DONE: begin
            end
        endcase

        if (body) begin
            if (len_nx == 4'd0 && off_nx == 4'd0) begin
                n_cluster  = clu + n_delta_acc;
                n_runs     = (runs != 16'hFFFF) ? runs + 16'd1 : runs;
                n_phase    = i_last_byte ? rld_pkg::PH_DONE : rld_pkg::PH_HEADER;
                n_byte_pos = 3'd0;
                push_c     = 1'b1;
                o_entry    = '{kind: rld_pkg::KIND_RUN, lcn: n_cluster,
                               len: n_length_acc, count: n_runs,
                               end_too: i_last_byte};
            end else if (i_last_byte) begin
                n_phase      = rld_pkg::PH_DONE;
                push_c       = 1'b1;
                o_entry.kind = rld_pkg::KIND_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rld_pkg::PH_HEADER;
            r_length_left <= 4'd0;
            r_offset_left <= 4'd0;
            r_byte_pos    <= 3'd0;
            r_length_acc  <= 64'd0;
            r_delta_acc   <= 64'd0;
            r_cluster     <= 64'd0;
            r_runs        <= 16'd0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_length_left <= n_length_left;
            r_offset_left <= n_offset_left;
            r_byte_pos    <= n_byte_pos;
            r_length_acc  <= n_length_acc;
            r_delta_acc   <= n_delta_acc;
            r_cluster     <= n_cluster;
            r_runs        <= n_runs;
        end
    end

    `RLD_ASSERT_IMP(a_done_silent, r_phase == rld_pkg::PH_DONE && !i_first_byte, !o_push, "word pushed after list end")
    `RLD_ASSERT_IMP(a_len_pending, r_phase == rld_pkg::PH_LENGTH, r_length_left != 4'd0, "length phase with no bytes due")

endmodule

>>> hw/rtl/rld_queue.sv
`include "ntfs_run_list_decoder_unit_defines.svh"

module rld_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rld_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rld_pkg::t_entry o_entry
);

    localparam int unsigned DEPTH = rld_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    rld_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `RLD_ASSERT_IMP(a_no_overrun, i_push, r_count != CW'(DEPTH), "push into full queue")
    `RLD_ASSERT_IMP(a_no_underrun, i_pop, r_count != '0, "pop from empty queue")

endmodule

>>> hw/rtl/rld_back.sv
`include "ntfs_run_list_decoder_unit_defines.svh"

module rld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_entry_valid,
    input  rld_pkg::t_entry    i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [63:0] o_start_lcn,
    output logic [63:0]        o_run_length,
    output logic [15:0]        o_run_count,
    output logic               o_last
);

    logic        r_valid;
    logic        r_pend;
    logic [1:0]  r_kind;
    logic [63:0] r_lcn;
    logic [63:0] r_len;
    logic [15:0] r_count;
    logic        r_last;
    logic        free;

    assign free  = !r_valid || !i_stall;
    assign o_pop = free && !r_pend && i_entry_valid;

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_start_lcn  = $signed(r_lcn);
    assign o_run_length = r_len;
    assign o_run_count  = r_count;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_entry_valid;
                r_pend  <= i_entry_valid && i_entry.end_too;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free) begin
            if (r_pend) begin
                r_kind <= rld_pkg::KIND_END;
                r_lcn  <= 64'd0;
                r_len  <= 64'd0;
                r_last <= 1'b1;
            end else if (i_entry_valid) begin
                r_kind  <= i_entry.kind;
                r_lcn   <= i_entry.lcn;
                r_len   <= i_entry.len;
                r_count <= i_entry.count;
                r_last  <= !i_entry.end_too;
            end
        end
    end

    `RLD_ASSERT_IMP(a_pend_follows_run, r_pend, r_valid && r_kind == rld_pkg::KIND_RUN && !r_last, "pending end without run word")

endmodule

>>> tb/ntfs_run_list_decoder_unit_tb.sv
module ntfs_run_list_decoder_unit_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_GOAL = 1300;
    localparam int PLAN_MAX = 32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] lcn;
        logic [63:0] len;
        logic [15:0] cnt;
        logic        eol;
    } t_rl_word;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       lastb;
        logic       fixed;
        t_rl_word   want;
    } t_rl_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_first_byte = 1'b0;
    logic               i_last_byte = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic signed [63:0] o_start_lcn;
    logic [63:0]        o_run_length;
    logic [15:0]        o_run_count;
    logic               o_last;

    ntfs_run_list_decoder_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .i_first_byte(i_first_byte),
        .i_last_byte(i_last_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_kind(o_kind),
        .o_start_lcn(o_start_lcn),
        .o_run_length(o_run_length),
        .o_run_count(o_run_count),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // run list decoder state
    logic [1:0]  phase_now = rld_pkg::PH_HEADER;
    logic [3:0]  len_due = 4'd0;
    logic [3:0]  off_due = 4'd0;
    logic [3:0]  off_bytes = 4'd0;
    logic [2:0]  byte_idx = 3'd0;
    logic [63:0] len_acc = 64'd0;
    logic [63:0] delta_acc = 64'd0;
    logic [63:0] cluster = 64'd0;
    logic [15:0] runs = 16'd0;

    t_rl_word step_out [2];
    int       step_n;

    t_rl_word words_due [$];
    t_rl_byte plan [PLAN_MAX];
    int       n_plan = 0;
    int       mismatches = 0;
    int       n_items = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;
    bit       want_hold = 1'b0;

    function automatic void note(logic [1:0] k, logic [63:0] lcn, logic [63:0] len,
                                 logic eol);
        step_out[step_n].kind = k;
        step_out[step_n].lcn = lcn;
        step_out[step_n].len = len;
        step_out[step_n].cnt = runs;
        step_out[step_n].eol = eol;
        step_n++;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic f, input logic lb);
        int          ot;
        logic [63:0] delta;
        step_n = 0;
        if (f) begin
            cluster = 64'd0;
            runs = 16'd0;
            phase_now = rld_pkg::PH_HEADER;
        end
        if (phase_now == rld_pkg::PH_DONE) return;
        if (phase_now == rld_pkg::PH_HEADER) begin
            if (b == 8'h00) begin
                phase_now = rld_pkg::PH_DONE;
                note(rld_pkg::KIND_END, 64'd0, 64'd0, 1'b1);
            end else if (lb) begin
                phase_now = rld_pkg::PH_DONE;
                note(rld_pkg::KIND_OVERFLOW, 64'd0, 64'd0, 1'b1);
            end else if (b[3:0] > rld_pkg::MAX_FIELD_BYTES
                         || b[7:4] > rld_pkg::MAX_FIELD_BYTES) begin
                phase_now = rld_pkg::PH_DONE;
                note(rld_pkg::KIND_MALFORMED, 64'd0, 64'd0, 1'b1);
            end else begin
                len_due = b[3:0];
                off_due = b[7:4];
                off_bytes = b[7:4];
                byte_idx = 3'd0;
                len_acc = 64'd0;
                delta_acc = 64'd0;
                phase_now = (b[3:0] != 4'd0) ? rld_pkg::PH_LENGTH : rld_pkg::PH_OFFSET;
            end
            return;
        end
        if (phase_now == rld_pkg::PH_LENGTH) begin
            len_acc |= {56'd0, b} << (8 * byte_idx);
            byte_idx++;
            if (len_due > 0) len_due--;
            if (len_due == 0) begin
                byte_idx = 3'd0;
                phase_now = rld_pkg::PH_OFFSET;
            end
        end else begin
            delta_acc |= {56'd0, b} << (8 * byte_idx);
            byte_idx++;
            if (off_due > 0) off_due--;
        end
        if (len_due == 0 && off_due == 0) begin
            ot = off_bytes;
            delta = delta_acc;
            if (ot != 0 && ot < 8) begin
                if (delta_acc[8 * ot - 1]) delta |= ~64'd0 << (8 * ot);
            end
            cluster += delta;
            if (runs != 16'hFFFF) runs++;
            phase_now = lb ? rld_pkg::PH_DONE : rld_pkg::PH_HEADER;
            byte_idx = 3'd0;
            note(rld_pkg::KIND_RUN, cluster, len_acc, !lb);
            if (lb) note(rld_pkg::KIND_END, 64'd0, 64'd0, 1'b1);
        end else if (lb) begin
            phase_now = rld_pkg::PH_DONE;
            note(rld_pkg::KIND_OVERFLOW, 64'd0, 64'd0, 1'b1);
        end
    endtask

    function automatic t_rl_byte row(logic [7:0] d, logic f, logic l);
        t_rl_byte r;
        r = '0;
        r.data = d;
        r.first = f;
        r.lastb = l;
        return r;
    endfunction

    // non-run word whose value is plain from the row itself
    function automatic t_rl_byte row_fixed(logic [7:0] d, logic f, logic l, logic [1:0] k,
                                           logic [15:0] c);
        t_rl_byte r;
        r = row(d, f, l);
        r.fixed = 1'b1;
        r.want.kind = k;
        r.want.cnt = c;
        r.want.eol = 1'b1;
        return r;
    endfunction

    function automatic void add_row(t_rl_byte r);
        plan[n_plan] = r;
        n_plan++;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send(input t_rl_byte it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data_byte <= it.data;
        i_first_byte <= it.first;
        i_last_byte <= it.lastb;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        n_items++;
        decode_byte(it.data, it.first, it.lastb);
        if (it.fixed) begin
            words_due = {words_due, it.want};
        end else begin
            for (int k = 0; k < step_n; k++) words_due = {words_due, step_out[k]};
        end
        @(negedge i_clk);
    endtask

    task automatic random_list();
        int         nruns;
        int         style;
        int         ln;
        int         on;
        int         total;
        int         cut;
        logic [3:0] bad;
        logic [3:0] other;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                send(row(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0));
            return;
        end
        nruns = $urandom_range(1, 5);
        style = $urandom_range(0, 9);
        for (int r = 0; r < nruns; r++) begin
            if ($urandom_range(0, 9) == 0) begin
                ln = $urandom_range(4, 8);
                on = $urandom_range(4, 8);
            end else begin
                ln = $urandom_range(0, 3);
                on = $urandom_range(0, 3);
            end
            if (ln == 0 && on == 0) ln = 1;
            total = ln + on;
            cut = (style == 7 && r == nruns - 1) ? int'($urandom_range(0, total - 1)) : -1;
            send(row({on[3:0], ln[3:0]}, r == 0, cut == 0));
            if (cut == 0) return;
            for (int k = 1; k <= total; k++) begin
                send(row(pick_byte(), 1'b0,
                         k == cut || (style == 6 && r == nruns - 1 && k == total)));
                if (k == cut) return;
            end
        end
        if (style == 8) begin
            bad = 4'($urandom_range(9, 15));
            other = 4'($urandom_range(0, 15));
            send(row($urandom_range(0, 1) ? {bad, other} : {other, bad}, 1'b0,
                     $urandom_range(0, 3) == 0));
        end else if (style < 6) begin
            send(row(8'h00, 1'b0, $urandom_range(0, 3) == 0));
        end
        repeat ($urandom_range(0, 2))
            send(row(pick_byte(), 1'b0, $urandom_range(0, 1) == 1));
    endtask

    // receiver stall patterns, plus one long hold-off
    initial begin
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (want_hold && !held) begin
                    held = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 2) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_rl_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind=%0d lcn=%h len=%h cnt=%0d last=%b",
                             o_kind, o_start_lcn, o_run_length, o_run_count, o_last);
            end else begin
                w = words_due.pop_front();
                if (o_kind !== w.kind || o_start_lcn !== w.lcn || o_run_length !== w.len ||
                    o_run_count !== w.cnt || o_last !== w.eol) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind=%0d lcn=%h len=%h cnt=%0d last=%b",
                                  " got kind=%0d lcn=%h len=%h cnt=%0d last=%b"},
                                 w.kind, w.lcn, w.len, w.cnt, w.eol, o_kind,
                                 o_start_lcn, o_run_length, o_run_count, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL ntfs_run_list_decoder_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        add_row(row_fixed(8'h00, 1'b0, 1'b0, rld_pkg::KIND_END, 16'd0));
        add_row(row(8'h21, 1'b1, 1'b0));
        add_row(row(8'hFF, 1'b0, 1'b0));
        add_row(row(8'h00, 1'b0, 1'b0));
        add_row(row(8'h80, 1'b0, 1'b0));
        add_row(row(8'h01, 1'b0, 1'b0));
        add_row(row(8'h07, 1'b0, 1'b0));
        add_row(row_fixed(8'h19, 1'b0, 1'b0, rld_pkg::KIND_MALFORMED, 16'd2));
        add_row(row(8'h00, 1'b0, 1'b0));
        add_row(row_fixed(8'h11, 1'b1, 1'b1, rld_pkg::KIND_OVERFLOW, 16'd0));
        add_row(row(8'h12, 1'b1, 1'b0));
        add_row(row_fixed(8'hAA, 1'b0, 1'b1, rld_pkg::KIND_OVERFLOW, 16'd0));
        add_row(row_fixed(8'hFF, 1'b1, 1'b0, rld_pkg::KIND_MALFORMED, 16'd0));
        add_row(row_fixed(8'h00, 1'b1, 1'b1, rld_pkg::KIND_END, 16'd0));
        add_row(row(8'h81, 1'b1, 1'b0));
        add_row(row(8'hFF, 1'b0, 1'b0));
        repeat (7) add_row(row(8'hFF, 1'b0, 1'b0));
        add_row(row(8'hFF, 1'b0, 1'b1));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < n_plan; i++) send(plan[i]);

        want_hold = 1'b1;
        while (n_items < ITEM_GOAL) random_list();

        i_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (words_due.size() != 0) begin
            mismatches += words_due.size();
            $display("%0d expected words never arrived", words_due.size());
        end
        if (mismatches == 0)
            $display("PASS ntfs_run_list_decoder_unit");
        else
            $display("FAIL ntfs_run_list_decoder_unit");
        $finish;
    end

endmodule
